[src/rfsd_pkg.sv]
// shared types, constants and functions for the remote frame sync decoder
// no dependencies
`timescale 1ns / 1ps

package rfsd_pkg;

  localparam int FRAME_BYTES = 21;
  localparam int IDX_W       = $clog2(FRAME_BYTES);
  localparam int Q_DEPTH     = 2;
  localparam int QPTR_W      = $clog2(Q_DEPTH);
  localparam int QCNT_W      = $clog2(Q_DEPTH + 1);
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 11;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8408;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_GOOD  = 2'd1,
    ST_RANGE = 2'd2,
    ST_CRC   = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOF_FIRST  = 8'd0,
    REG_SOF_SECOND = 8'd1,
    REG_OFFSET     = 8'd2,
    REG_LIMIT      = 8'd3
  } reg_idx_t;

  localparam logic [1:0] SWITCH_RANGE = 2'd2;
  localparam logic [1:0] SWITCH_MAP [4] = '{2'd2, 2'd3, 2'd1, 2'd2};

  typedef struct packed {
    logic [7:0]  sof_first;
    logic [7:0]  sof_second;
    logic [10:0] offset;
    logic [10:0] limit;
  } cfg_t;

  // one classified item handed from front to back
  typedef struct packed {
    logic             wr;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
    logic             last;
    logic             crc_ok;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    status_t            frame_status;
    logic signed [11:0] chan_0;
    logic signed [11:0] chan_1;
    logic signed [11:0] chan_2;
    logic signed [11:0] chan_3;
    logic signed [11:0] chan_4;
    logic [1:0]         switch_code;
    logic signed [15:0] pointer_x;
    logic signed [15:0] pointer_y;
    logic signed [15:0] pointer_z;
    logic [15:0]        key_bits;
    logic [7:0]         button_bits;
  } res_t;

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[src/rfsd_if.sv]
// channel interfaces for the remote frame sync decoder
// does not depend on rfsd_pkg
`timescale 1ns / 1ps

interface rfsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rfsd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         frame_status;
  logic signed [11:0] chan_0;
  logic signed [11:0] chan_1;
  logic signed [11:0] chan_2;
  logic signed [11:0] chan_3;
  logic signed [11:0] chan_4;
  logic [1:0]         switch_code;
  logic signed [15:0] pointer_x;
  logic signed [15:0] pointer_y;
  logic signed [15:0] pointer_z;
  logic [15:0]        key_bits;
  logic [7:0]         button_bits;
  modport source (output valid, output frame_status, output chan_0, output chan_1,
                  output chan_2, output chan_3, output chan_4, output switch_code,
                  output pointer_x, output pointer_y, output pointer_z,
                  output key_bits, output button_bits, input ready);
  modport sink (input valid, input frame_status, input chan_0, input chan_1,
                input chan_2, input chan_3, input chan_4, input switch_code,
                input pointer_x, input pointer_y, input pointer_z,
                input key_bits, input button_bits, output ready);
endinterface

interface rfsd_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  reg_index;
  logic [10:0] wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

[src/remote_frame_sync_decoder_core.sv]
// remote frame sync decoder top level: config registers, front, queue and back
// an accepted item waits in the queue; its result is registered in the back when it is popped
// throughput: one item per cycle unless the queue is full; the crc step is combinational
// reset: synchronous active-low rst_n returns the hunt, crc, queue and result valid
// to their idle values and the config registers to their defaults
`timescale 1ns / 1ps

module remote_frame_sync_decoder_core import rfsd_pkg::*; (
  input logic           clk,
  input logic           rst_n,
  rfsd_in_if.sink       in_ch,
  rfsd_out_if.source    out_ch,
  rfsd_cfg_if.sink      cfg_ch
);

  cfg_t    cfg_r;
  op_t     front_op;
  op_t     head_op;
  q_stat_t q_stat;
  logic    push;
  logic    pop;
  logic    res_valid;
  res_t    res;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sof_first  <= 8'hA9;
      cfg_r.sof_second <= 8'h53;
      cfg_r.offset     <= 11'd1024;
      cfg_r.limit      <= 11'd700;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        REG_SOF_FIRST:  cfg_r.sof_first  <= cfg_ch.wdata[7:0];
        REG_SOF_SECOND: cfg_r.sof_second <= cfg_ch.wdata[7:0];
        REG_OFFSET:     cfg_r.offset     <= cfg_ch.wdata;
        REG_LIMIT:      cfg_r.limit      <= cfg_ch.wdata;
        default:        cfg_r            <= cfg_r;
      endcase
    end
  end

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;
  assign pop         = !q_stat.empty && (!res_valid || out_ch.ready);

  rfsd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .push    (push),
    .rx_byte (in_ch.rx_byte),
    .op      (front_op)
  );

  rfsd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (front_op),
    .pop     (pop),
    .head    (head_op),
    .stat    (q_stat)
  );

  rfsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop       (pop),
    .op        (head_op),
    .res_taken (out_ch.ready),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_ch.valid        = res_valid;
  assign out_ch.frame_status = res.frame_status;
  assign out_ch.chan_0       = res.chan_0;
  assign out_ch.chan_1       = res.chan_1;
  assign out_ch.chan_2       = res.chan_2;
  assign out_ch.chan_3       = res.chan_3;
  assign out_ch.chan_4       = res.chan_4;
  assign out_ch.switch_code  = res.switch_code;
  assign out_ch.pointer_x    = res.pointer_x;
  assign out_ch.pointer_y    = res.pointer_y;
  assign out_ch.pointer_z    = res.pointer_z;
  assign out_ch.key_bits     = res.key_bits;
  assign out_ch.button_bits  = res.button_bits;

`ifndef SYNTH
  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  a_bad_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.frame_status != ST_GOOD |->
      out_ch.chan_0 == '0 && out_ch.chan_4 == '0 && out_ch.pointer_x == '0 &&
      out_ch.key_bits == '0 && out_ch.button_bits == '0)
    else $error("non-good result carries payload");

  a_switch_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |->
      (out_ch.frame_status == ST_NONE && out_ch.switch_code == 2'd0) ||
      (out_ch.frame_status == ST_CRC && out_ch.switch_code == 2'd0) ||
      (out_ch.frame_status == ST_RANGE && out_ch.switch_code == SWITCH_RANGE) ||
      (out_ch.frame_status == ST_GOOD && out_ch.switch_code != 2'd0))
    else $error("switch code does not match frame status");
`endif

endmodule

[src/rfsd_front.sv]
// front end: start byte hunt, byte counting and running crc, classifies each item
// depends on rfsd_pkg
`timescale 1ns / 1ps

module rfsd_front import rfsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       push,
  input  logic [7:0] rx_byte,
  output op_t        op
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_SOF2,
    PH_DATA
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [IDX_W-1:0] count_r, count_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       crc_lo_r, crc_lo_nxt;

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    crc_nxt    = crc_r;
    crc_lo_nxt = crc_lo_r;
    op         = '0;
    op.data    = rx_byte;
    case (phase_r)
      PH_SOF2: begin
        if (rx_byte == cfg.sof_second) begin
          op.wr     = 1'b1;
          op.idx    = IDX_W'(1);
          crc_nxt   = crc16_step(crc_r, rx_byte);
          count_nxt = IDX_W'(2);
          phase_nxt = PH_DATA;
        end else if (rx_byte == cfg.sof_first) begin
          op.wr   = 1'b1;
          op.idx  = '0;
          crc_nxt = crc16_step(CRC_INIT, rx_byte);
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_DATA: begin
        op.wr  = 1'b1;
        op.idx = count_r;
        if (count_r < IDX_W'(FRAME_BYTES - 2)) begin
          crc_nxt = crc16_step(crc_r, rx_byte);
        end
        if (count_r == IDX_W'(FRAME_BYTES - 2)) begin
          crc_lo_nxt = rx_byte;
        end
        if (count_r == IDX_W'(FRAME_BYTES - 1)) begin
          op.last   = 1'b1;
          op.crc_ok = ({rx_byte, crc_lo_r} == crc_r);
          phase_nxt = PH_HUNT;
          count_nxt = '0;
        end else begin
          count_nxt = count_r + IDX_W'(1);
        end
      end
      default: begin
        count_nxt = '0;
        if (rx_byte == cfg.sof_first) begin
          op.wr     = 1'b1;
          op.idx    = '0;
          crc_nxt   = crc16_step(CRC_INIT, rx_byte);
          phase_nxt = PH_SOF2;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      count_r  <= '0;
      crc_r    <= CRC_INIT;
      crc_lo_r <= '0;
    end else if (push) begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      crc_r    <= crc_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

endmodule

[src/rfsd_queue.sv]
// short fifo of classified items between front and back
// depends on rfsd_pkg
`timescale 1ns / 1ps

module rfsd_queue import rfsd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  op_t     push_op,
  input  logic    pop,
  output op_t     head,
  output q_stat_t stat
);

  op_t               mem_r [Q_DEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign head       = mem_r[rptr_r];
  assign stat.full  = (cnt_r == QCNT_W'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rptr_r + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[src/rfsd_back.sv]
// back end: frame byte store, field decode, range check and result register
// depends on rfsd_pkg
`timescale 1ns / 1ps

module rfsd_back import rfsd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic pop,
  input  op_t  op,
  input  logic res_taken,
  output logic res_valid,
  output res_t res
);

  logic [7:0]         store_r [FRAME_BYTES];
  logic               valid_r, valid_nxt;
  res_t               res_r, res_nxt;
  logic [63:0]        pk;
  logic [10:0]        raw [5];
  logic signed [11:0] ch [5];
  logic [11:0]        mag [4];
  logic               range_err;
  logic [7:0]         mb;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pk[i*8 +: 8] = store_r[2 + i];
    end
    raw[0] = pk[10:0];
    raw[1] = pk[21:11];
    raw[2] = pk[43:33];
    raw[3] = pk[32:22];
    raw[4] = pk[59:49];
    for (int i = 0; i < 5; i++) begin
      ch[i] = $signed({1'b0, raw[i]}) - $signed({1'b0, cfg.offset});
    end
    range_err = 1'b0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = ch[i][11] ? 12'(-ch[i]) : 12'(ch[i]);
      if (mag[i] > {1'b0, cfg.limit}) begin
        range_err = 1'b1;
      end
    end
    mb = store_r[16];
  end

  always_comb begin
    res_nxt = '0;
    res_nxt.frame_status = ST_NONE;
    if (op.last) begin
      if (!op.crc_ok) begin
        res_nxt.frame_status = ST_CRC;
      end else if (range_err) begin
        res_nxt.frame_status = ST_RANGE;
        res_nxt.switch_code  = SWITCH_RANGE;
      end else begin
        res_nxt.frame_status = ST_GOOD;
        res_nxt.chan_0       = ch[0];
        res_nxt.chan_1       = ch[1];
        res_nxt.chan_2       = ch[2];
        res_nxt.chan_3       = ch[3];
        res_nxt.chan_4       = ch[4];
        res_nxt.switch_code  = SWITCH_MAP[pk[45:44]];
        res_nxt.pointer_x    = {store_r[11], store_r[10]};
        res_nxt.pointer_y    = {store_r[13], store_r[12]};
        res_nxt.pointer_z    = {store_r[15], store_r[14]};
        res_nxt.key_bits     = {store_r[18], store_r[17]};
        res_nxt.button_bits  = {pk[60], pk[48], pk[47], pk[46], mb[5:4], mb[1], mb[0]};
      end
    end
    valid_nxt = pop ? 1'b1 : (valid_r && !res_taken);
  end

  always_ff @(posedge clk) begin
    if (pop && op.wr) begin
      store_r[op.idx] <= op.data;
    end
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign res_valid = valid_r;
  assign res       = res_r;

endmodule
